@@ src/lla_pkg.sv @@
package lla_pkg;

  // Grid storage limits
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int MIN_DIM    = 3;

  // Field and register widths
  localparam int MODE_W     = 2;
  localparam int DIM_CFG_W  = 8;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CNT_W      = 15;
  localparam int CNT_MAX    = (2 ** CNT_W) - 1;

  // Register reset values
  localparam logic [DIM_CFG_W-1:0] RST_GRID_WIDTH   = 8'd64;
  localparam logic [DIM_CFG_W-1:0] RST_GRID_HEIGHT  = 8'd64;
  localparam logic [MASK_W-1:0]    RST_SURVIVE_MASK = 9'b000001100;
  localparam logic [MASK_W-1:0]    RST_BIRTH_MASK   = 9'b000001000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MASK   = 2'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_STEP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Change counter pipeline: groups of bits, then groups of partials
  localparam int CNT_GROUP  = 8;
  localparam int CNT_GROUPS = (MAX_WIDTH + CNT_GROUP - 1) / CNT_GROUP;
  localparam int CNT_FAN    = 4;
  localparam int CNT_QUADS  = (CNT_GROUPS + CNT_FAN - 1) / CNT_FAN;
  localparam int CNT_DRAIN  = 3;

  typedef struct packed {
    logic clear;
    logic valid;
  } cnt_ctl_t;

endpackage

@@ src/lla_ram.sv @@
module lla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lla_row_rule.sv @@
module lla_row_rule (
  input  logic [lla_pkg::MAX_WIDTH-1:0] above,
  input  logic [lla_pkg::MAX_WIDTH-1:0] mid,
  input  logic [lla_pkg::MAX_WIDTH-1:0] below,
  input  logic [lla_pkg::COL_W-1:0]     w_last,
  input  logic [lla_pkg::MASK_W-1:0]    survive_mask,
  input  logic [lla_pkg::MASK_W-1:0]    birth_mask,
  output logic [lla_pkg::MAX_WIDTH-1:0] next_row,
  output logic [lla_pkg::MAX_WIDTH-1:0] diff_row
);

  // wrap taps for the first column
  logic a_wrap, m_wrap, b_wrap;

  assign a_wrap = above[w_last];
  assign m_wrap = mid[w_last];
  assign b_wrap = below[w_last];

  always_comb begin
    logic       al, ar, ml, mr, bl, br;
    logic [3:0] n;
    logic       nxt;
    next_row = mid;
    diff_row = '0;
    for (int c = 0; c < lla_pkg::MAX_WIDTH; c++) begin
      if (c == 0) begin
        al = a_wrap;
        ml = m_wrap;
        bl = b_wrap;
      end else begin
        al = above[c-1];
        ml = mid[c-1];
        bl = below[c-1];
      end
      if (lla_pkg::COL_W'(c) == w_last) begin
        ar = above[0];
        mr = mid[0];
        br = below[0];
      end else begin
        ar = above[(c + 1) % lla_pkg::MAX_WIDTH];
        mr = mid[(c + 1) % lla_pkg::MAX_WIDTH];
        br = below[(c + 1) % lla_pkg::MAX_WIDTH];
      end
      n = {3'b000, al} + {3'b000, above[c]} + {3'b000, ar}
        + {3'b000, ml} + {3'b000, mr}
        + {3'b000, bl} + {3'b000, below[c]} + {3'b000, br};
      if (!survive_mask[n]) begin
        nxt = 1'b0;
      end else if (birth_mask[n]) begin
        nxt = 1'b1;
      end else begin
        nxt = mid[c];
      end
      // columns past the wrap point keep their value
      if (lla_pkg::COL_W'(c) <= w_last) begin
        next_row[c] = nxt;
        diff_row[c] = nxt ^ mid[c];
      end
    end
  end

endmodule

@@ src/lla_count.sv @@
module lla_count (
  input  logic                          clk,
  input  logic                          rst,
  input  lla_pkg::cnt_ctl_t             ctl,
  input  logic [lla_pkg::MAX_WIDTH-1:0] diff_row,
  output logic [lla_pkg::CNT_W-1:0]     total
);

  localparam int PART_W = $clog2(lla_pkg::CNT_GROUP + 1);
  localparam int QUAD_W = PART_W + $clog2(lla_pkg::CNT_FAN);

  logic [lla_pkg::MAX_WIDTH-1:0] diff_q;
  logic [PART_W-1:0]             part      [lla_pkg::CNT_GROUPS];
  logic [PART_W-1:0]             part_next [lla_pkg::CNT_GROUPS];
  logic [QUAD_W-1:0]             quad      [lla_pkg::CNT_QUADS];
  logic [QUAD_W-1:0]             quad_next [lla_pkg::CNT_QUADS];
  logic [lla_pkg::CNT_W:0]       sum_next;
  logic                          v1, v2, v3;

  always_comb begin
    for (int g = 0; g < lla_pkg::CNT_GROUPS; g++) begin
      part_next[g] = '0;
      for (int i = 0; i < lla_pkg::CNT_GROUP; i++) begin
        if (g * lla_pkg::CNT_GROUP + i < lla_pkg::MAX_WIDTH) begin
          part_next[g] = part_next[g]
                       + PART_W'(diff_q[g * lla_pkg::CNT_GROUP + i]);
        end
      end
    end
  end

  always_comb begin
    for (int q = 0; q < lla_pkg::CNT_QUADS; q++) begin
      quad_next[q] = '0;
      for (int k = 0; k < lla_pkg::CNT_FAN; k++) begin
        if (q * lla_pkg::CNT_FAN + k < lla_pkg::CNT_GROUPS) begin
          quad_next[q] = quad_next[q]
                       + QUAD_W'(part[q * lla_pkg::CNT_FAN + k]);
        end
      end
    end
  end

  always_comb begin
    sum_next = {1'b0, total};
    for (int q = 0; q < lla_pkg::CNT_QUADS; q++) begin
      sum_next = sum_next + (lla_pkg::CNT_W + 1)'(quad[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      total <= '0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        // saturate
        if (sum_next > (lla_pkg::CNT_W + 1)'(lla_pkg::CNT_MAX)) begin
          total <= lla_pkg::CNT_W'(lla_pkg::CNT_MAX);
        end else begin
          total <= sum_next[lla_pkg::CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      diff_q <= diff_row;
    end
    part <= part_next;
    quad <= quad_next;
  end

endmodule

@@ src/life_like_automaton_step.sv @@
// Cell write or read: the row is read, then written back (write) or the cell taken (read),
// and the result loads; a cell outside the region or the unused mode skips to the result.
// Generation: S_GEN_TOP and S_GEN_LAST prime the row window, S_GEN_ROW reads one row and
// writes one back for each row, S_DRAIN empties the change counter, then the result loads.
// One transaction at a time; the next is taken the cycle after the result loads.
// Reset: per-row valid bits clear at once so all cells read dead; registers 64/64/12/8.
module life_like_automaton_step (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lla_pkg::MODE_W-1:0]      mode,
  input  logic [6:0]                      col,
  input  logic [6:0]                      row,
  input  logic                            cell_in,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            cell_out,
  output logic [lla_pkg::CNT_W-1:0]       changed_count,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lla_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // One-hot sequencer
  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_CELL_WAIT = 8'b0000_0010, // row data back; cell write-back or read out
    S_GEN_TOP   = 8'b0000_0100, // row 0 back; saved for the bottom wrap
    S_GEN_LAST  = 8'b0000_1000, // last row back; above-neighbor of row 0
    S_GEN_ROW   = 8'b0001_0000, // one row per cycle: compute, write, read ahead
    S_DRAIN     = 8'b0010_0000, // change counter pipeline empties
    S_DONE      = 8'b0100_0000  // result to the output register
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [lla_pkg::DIM_CFG_W-1:0] grid_width;
  logic [lla_pkg::DIM_CFG_W-1:0] grid_height;
  logic [lla_pkg::MASK_W-1:0]    survive_mask;
  logic [lla_pkg::MASK_W-1:0]    birth_mask;

  // clamped extents, expressed as last index in use
  logic [lla_pkg::COL_W-1:0] w_last;
  logic [lla_pkg::ROW_W-1:0] h_last;
  logic                      in_grid;

  // transaction held while it runs
  logic                      op_write;
  logic                      op_gen;
  logic [lla_pkg::COL_W-1:0] op_col;
  logic [lla_pkg::ROW_W-1:0] op_row;
  logic                      op_val;
  logic                      res_cell;

  // generation sweep
  logic [lla_pkg::ROW_W-1:0]                   gen_row;
  logic [$clog2(lla_pkg::CNT_DRAIN)-1:0]       drain;
  logic                                        last_row;
  logic                                        read_ahead;
  logic [lla_pkg::MAX_WIDTH-1:0]               hold_top;
  logic [lla_pkg::MAX_WIDTH-1:0]               hold_prev;
  logic [lla_pkg::MAX_WIDTH-1:0]               hold_cur;
  logic [lla_pkg::MAX_WIDTH-1:0]               below;
  logic [lla_pkg::MAX_WIDTH-1:0]               next_row;
  logic [lla_pkg::MAX_WIDTH-1:0]               diff_row;

  // row memory and its reset-time valid bits
  logic                          ram_we, ram_re;
  logic [lla_pkg::ROW_W-1:0]     ram_waddr, ram_raddr;
  logic [lla_pkg::MAX_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [lla_pkg::MAX_HEIGHT-1:0] row_valid;
  logic                          rd_ok;
  logic [lla_pkg::MAX_WIDTH-1:0] rd_row;
  logic [lla_pkg::MAX_WIDTH-1:0] cell_row;

  lla_pkg::cnt_ctl_t         cnt_ctl;
  logic [lla_pkg::CNT_W-1:0] cnt_total;

  logic out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // Size clamp to 3..max
  always_comb begin
    if (32'(grid_width) > lla_pkg::MAX_WIDTH) begin
      w_last = lla_pkg::COL_W'(lla_pkg::MAX_WIDTH - 1);
    end else if (grid_width < lla_pkg::DIM_CFG_W'(lla_pkg::MIN_DIM)) begin
      w_last = lla_pkg::COL_W'(lla_pkg::MIN_DIM - 1);
    end else begin
      w_last = lla_pkg::COL_W'(grid_width - 8'd1);
    end
    if (32'(grid_height) > lla_pkg::MAX_HEIGHT) begin
      h_last = lla_pkg::ROW_W'(lla_pkg::MAX_HEIGHT - 1);
    end else if (grid_height < lla_pkg::DIM_CFG_W'(lla_pkg::MIN_DIM)) begin
      h_last = lla_pkg::ROW_W'(lla_pkg::MIN_DIM - 1);
    end else begin
      h_last = lla_pkg::ROW_W'(grid_height - 8'd1);
    end
  end

  assign in_grid = (32'(col) <= 32'(w_last)) && (32'(row) <= 32'(h_last));

  // A row never written since reset reads as all dead
  assign rd_row = rd_ok ? ram_rdata : '0;

  always_comb begin
    cell_row         = rd_row;
    cell_row[op_col] = op_val;
  end

  // Bottom row wraps to the saved original row 0
  assign last_row   = (gen_row == h_last);
  assign below      = last_row ? hold_top : rd_row;
  assign read_ahead = ({1'b0, gen_row} + (lla_pkg::ROW_W + 1)'(2)) <= {1'b0, h_last};

  lla_row_rule u_rule (
    .above        (hold_prev),
    .mid          (hold_cur),
    .below        (below),
    .w_last       (w_last),
    .survive_mask (survive_mask),
    .birth_mask   (birth_mask),
    .next_row     (next_row),
    .diff_row     (diff_row)
  );

  lla_count u_count (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cnt_ctl),
    .diff_row (diff_row),
    .total    (cnt_total)
  );

  lla_ram #(
    .WIDTH (lla_pkg::MAX_WIDTH),
    .DEPTH (lla_pkg::MAX_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and memory control
  always_comb begin
    state_next = state;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = cell_row;
    cnt_ctl    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (lla_pkg::mode_t'(mode))
            lla_pkg::MODE_WRITE, lla_pkg::MODE_READ: begin
              if (in_grid) begin
                ram_re     = 1'b1;
                ram_raddr  = lla_pkg::ROW_W'(row);
                state_next = S_CELL_WAIT;
              end else begin
                state_next = S_DONE;
              end
            end
            lla_pkg::MODE_STEP: begin
              ram_re        = 1'b1;
              ram_raddr     = '0;
              cnt_ctl.clear = 1'b1;
              state_next    = S_GEN_TOP;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_CELL_WAIT: begin
        if (op_write) begin
          ram_we    = 1'b1;
          ram_waddr = op_row;
          ram_wdata = cell_row;
        end
        state_next = S_DONE;
      end
      S_GEN_TOP: begin
        ram_re     = 1'b1;
        ram_raddr  = h_last;
        state_next = S_GEN_LAST;
      end
      S_GEN_LAST: begin
        ram_re     = 1'b1;
        ram_raddr  = lla_pkg::ROW_W'(1);
        state_next = S_GEN_ROW;
      end
      S_GEN_ROW: begin
        // row r goes back while row r+2, if in use, is fetched; r+1 is on the read port now
        ram_we        = 1'b1;
        ram_waddr     = gen_row;
        ram_wdata     = next_row;
        cnt_ctl.valid = 1'b1;
        if (read_ahead) begin
          ram_re    = 1'b1;
          ram_raddr = gen_row + lla_pkg::ROW_W'(2);
        end
        if (last_row) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain == ($clog2(lla_pkg::CNT_DRAIN))'(lla_pkg::CNT_DRAIN - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      row_valid    <= '0;
      rd_ok        <= 1'b0;
      gen_row      <= '0;
      drain        <= '0;
      grid_width   <= lla_pkg::RST_GRID_WIDTH;
      grid_height  <= lla_pkg::RST_GRID_HEIGHT;
      survive_mask <= lla_pkg::RST_SURVIVE_MASK;
      birth_mask   <= lla_pkg::RST_BIRTH_MASK;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lla_pkg::CFG_GRID_WIDTH:   grid_width   <= cfg_data[lla_pkg::DIM_CFG_W-1:0];
          lla_pkg::CFG_GRID_HEIGHT:  grid_height  <= cfg_data[lla_pkg::DIM_CFG_W-1:0];
          lla_pkg::CFG_SURVIVE_MASK: survive_mask <= cfg_data[lla_pkg::MASK_W-1:0];
          lla_pkg::CFG_BIRTH_MASK:   birth_mask   <= cfg_data[lla_pkg::MASK_W-1:0];
          default: ;
        endcase
      end
      if (ram_re) begin
        rd_ok <= row_valid[ram_raddr];
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
      if (state == S_GEN_LAST) begin
        gen_row <= '0;
      end else if (state == S_GEN_ROW) begin
        gen_row <= gen_row + lla_pkg::ROW_W'(1);
      end
      if (state == S_GEN_ROW) begin
        drain <= '0;
      end else if (state == S_DRAIN) begin
        drain <= drain + ($clog2(lla_pkg::CNT_DRAIN))'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_write <= (lla_pkg::mode_t'(mode) == lla_pkg::MODE_WRITE);
      op_gen   <= (lla_pkg::mode_t'(mode) == lla_pkg::MODE_STEP);
      op_col   <= lla_pkg::COL_W'(col);
      op_row   <= lla_pkg::ROW_W'(row);
      op_val   <= cell_in;
      res_cell <= 1'b0;
    end
    if (state == S_CELL_WAIT) begin
      res_cell <= op_write ? 1'b0 : rd_row[op_col];
    end
    if (state == S_GEN_TOP) begin
      hold_top <= rd_row;
      hold_cur <= rd_row;
    end
    if (state == S_GEN_LAST) begin
      hold_prev <= rd_row;
    end
    if (state == S_GEN_ROW) begin
      hold_prev <= hold_cur;
      hold_cur  <= below;
    end
    if (out_load) begin
      cell_out      <= res_cell;
      changed_count <= op_gen ? cnt_total : '0;
    end
  end

  // Assertions
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("row memory read and write hit the same row");

  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CELL_WAIT || state == S_GEN_ROW))
    else $error("row memory written outside a write-back state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result presented without a finished transaction");

  a_done_clears_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_GEN_ROW && last_row) |=> (state == S_DRAIN))
    else $error("generation sweep did not move to drain after the last row");

endmodule
